>>> rtl/core/tns_pkg.sv
package tns_pkg;

   localparam int SIM_W    = 17;
   localparam int TCOUNT_W = 7;
   localparam int RANK_W   = 6;
   localparam int OUT_ID_W = 32;

   localparam logic [TCOUNT_W-1:0] T_COUNT_RESET = 7'd20;

   typedef struct packed {
      logic [OUT_ID_W-1:0] neighbor_id;
      logic [SIM_W-1:0]    similarity;
      logic                last_edge;
   } req_payload_type;

   typedef struct packed {
      logic [RANK_W-1:0]   rank;
      logic [OUT_ID_W-1:0] held_id;
      logic [SIM_W-1:0]    held_similarity;
      logic                filled;
      logic                last_of_run;
   } rsp_payload_type;

   // per-cycle command broadcast to every slot of the chain
   typedef struct packed {
      logic insert;   // place the broadcast entry, shift lower ranks down
      logic drain;    // every slot takes its right neighbour
      logic clear;    // empty the whole list
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

endpackage

>>> rtl/core/tns_chan_if.sv
interface tns_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tns_cell.sv
module tns_cell #(
   parameter int ID_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tns_pkg::cell_ctrl_type      ctrl,
   input  logic [tns_pkg::SIM_W-1:0]   new_sim,
   input  logic [ID_BITS-1:0]          new_id,
   input  logic                        left_take,
   input  logic [tns_pkg::SIM_W-1:0]   left_sim,
   input  logic [ID_BITS-1:0]          left_id,
   input  logic                        left_valid,
   input  logic [tns_pkg::SIM_W-1:0]   right_sim,
   input  logic [ID_BITS-1:0]          right_id,
   input  logic                        right_valid,
   output logic                        take,
   output logic [tns_pkg::SIM_W-1:0]   sim,
   output logic [ID_BITS-1:0]          id,
   output logic                        valid
);
   import tns_pkg::*;

   logic [SIM_W-1:0]   sim_ff, sim_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               valid_ff, valid_in;

   // new entry ranks ahead of this slot: slot empty, or strictly worse (ties stay ahead)
   assign take = !valid_ff || (sim_ff < new_sim);

   always_comb begin
      sim_in   = sim_ff;
      id_in    = id_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.drain) begin
         sim_in   = right_sim;
         id_in    = right_id;
         valid_in = right_valid;
      end else if (ctrl.insert && take) begin
         if (left_take) begin
            sim_in   = left_sim;
            id_in    = left_id;
            valid_in = left_valid;
         end else begin
            sim_in   = new_sim;
            id_in    = new_id;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sim_ff <= sim_in;
      id_ff  <= id_in;
   end

   assign sim   = sim_ff;
   assign id    = id_ff;
   assign valid = valid_ff;

endmodule

>>> rtl/core/tns_chain.sv
module tns_chain #(
   parameter int MAX_T   = 64,
   parameter int ID_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tns_pkg::cell_ctrl_type      ctrl,
   input  logic [tns_pkg::SIM_W-1:0]   new_sim,
   input  logic [ID_BITS-1:0]          new_id,
   output logic [tns_pkg::SIM_W-1:0]   head_sim,
   output logic [ID_BITS-1:0]          head_id,
   output logic                        head_valid,
   output logic [MAX_T-1:0]            valid_vec
);
   import tns_pkg::*;

   logic [SIM_W-1:0]   sim_q  [MAX_T];
   logic [ID_BITS-1:0] id_q   [MAX_T];
   logic [MAX_T-1:0]   take_q;

   genvar i;
   generate
      for (i = 0; i < MAX_T; i++) begin : g_slot
         logic               l_take, r_valid;
         logic [SIM_W-1:0]   l_sim, r_sim;
         logic [ID_BITS-1:0] l_id, r_id;
         logic               l_valid;

         if (i == 0) begin : g_first
            assign l_take  = 1'b0;
            assign l_sim   = new_sim;
            assign l_id    = new_id;
            assign l_valid = 1'b1;
         end else begin : g_mid
            assign l_take  = take_q[i-1];
            assign l_sim   = sim_q[i-1];
            assign l_id    = id_q[i-1];
            assign l_valid = valid_vec[i-1];
         end

         if (i == MAX_T-1) begin : g_last
            assign r_sim   = '0;
            assign r_id    = '0;
            assign r_valid = 1'b0;
         end else begin : g_inner
            assign r_sim   = sim_q[i+1];
            assign r_id    = id_q[i+1];
            assign r_valid = valid_vec[i+1];
         end

         tns_cell #(
            .ID_BITS (ID_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_sim     (new_sim),
            .new_id      (new_id),
            .left_take   (l_take),
            .left_sim    (l_sim),
            .left_id     (l_id),
            .left_valid  (l_valid),
            .right_sim   (r_sim),
            .right_id    (r_id),
            .right_valid (r_valid),
            .take        (take_q[i]),
            .sim         (sim_q[i]),
            .id          (id_q[i]),
            .valid       (valid_vec[i])
         );
      end
   endgenerate

   assign head_sim   = sim_q[0];
   assign head_id    = id_q[0];
   assign head_valid = valid_vec[0];

endmodule

>>> rtl/core/top_t_neighbor_selection.sv
// Streaming top-t neighbour selection. Edges of one vertex arrive as
// (neighbor_id, similarity) beats; a row of MAX_T slots keeps the best of them
// sorted by descending similarity, an older entry staying ahead on a tie.
// While filling, one edge beat is taken every cycle: each slot compares the
// broadcast similarity with its own and either holds, takes its left
// neighbour or takes the new entry, all in the same cycle. A beat marked
// last_edge is inserted too, then the list drains through slot 0 as t result
// beats (rank 0 first), one per cycle while rsp_chan.ready is high; req is
// held off during the drain. t is t_count, with 0 read as 1 and values above
// MAX_T read as MAX_T. Empty slots come out with filled low and zero id and
// similarity; last_of_run marks rank t-1, whose similarity is the threshold.
// The list is empty again the cycle after the final beat. t_count is to be
// written through csr_chan only while no vertex is in progress; the block
// does not enforce this itself. Reset value 20.
module top_t_neighbor_selection #(
   parameter int MAX_T   = 64,
   parameter int ID_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   tns_chan_if.sink   req_chan,
   tns_chan_if.source rsp_chan,
   tns_chan_if.sink   csr_chan
);
   import tns_pkg::*;

   localparam int CNT_W = (MAX_T > 1) ? $clog2(MAX_T) : 1;
   localparam logic [TCOUNT_W-1:0] MAX_T_C = TCOUNT_W'(MAX_T);

   // control
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    rank_ff, rank_in;
   logic [TCOUNT_W-1:0] t_count_ff, t_count_in;
   cell_ctrl_type       ctrl;

   // chain head
   logic [SIM_W-1:0]    head_sim;
   logic [ID_BITS-1:0]  head_id;
   logic                head_valid;
   logic [MAX_T-1:0]    valid_vec;

   logic [TCOUNT_W-1:0] t_eff, last_rank;
   logic                req_beat, rsp_beat, final_rank;

   // effective t: zero reads as one, saturate at the slot count
   always_comb begin
      if (t_count_ff == '0) begin
         t_eff = TCOUNT_W'(1);
      end else if (t_count_ff > MAX_T_C) begin
         t_eff = MAX_T_C;
      end else begin
         t_eff = t_count_ff;
      end
   end

   assign last_rank  = t_eff - TCOUNT_W'(1);
   assign final_rank = (TCOUNT_W'(rank_ff) == last_rank);

   assign req_chan.ready = (state_ff == ST_FILL);
   assign csr_chan.ready = 1'b1;
   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;

   // config register
   assign t_count_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : t_count_ff;

   always_comb begin
      state_in    = state_ff;
      rank_in     = rank_ff;
      ctrl        = '0;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         ST_FILL: begin
            ctrl.insert = req_beat;
            if (req_beat && req_chan.data.last_edge) begin
               state_in = ST_DRAIN;
               rank_in  = '0;
            end
         end
         ST_DRAIN: begin
            rsp_chan.valid = 1'b1;
            if (rsp_beat) begin
               if (final_rank) begin
                  // drop whatever is left beyond rank t-1
                  ctrl.clear = 1'b1;
                  state_in   = ST_FILL;
               end else begin
                  ctrl.drain = 1'b1;
                  rank_in    = rank_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         rank_ff    <= '0;
         t_count_ff <= T_COUNT_RESET;
      end else begin
         state_ff   <= state_in;
         rank_ff    <= rank_in;
         t_count_ff <= t_count_in;
      end
   end

   tns_chain #(
      .MAX_T   (MAX_T),
      .ID_BITS (ID_BITS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .new_sim    (req_chan.data.similarity),
      .new_id     (ID_BITS'(req_chan.data.neighbor_id)),
      .head_sim   (head_sim),
      .head_id    (head_id),
      .head_valid (head_valid),
      .valid_vec  (valid_vec)
   );

   // result beat straight off slot 0; empty slot reads as zero
   assign rsp_chan.data.rank            = RANK_W'(rank_ff);
   assign rsp_chan.data.held_id         = head_valid ? OUT_ID_W'(head_id) : '0;
   assign rsp_chan.data.held_similarity = head_valid ? head_sim : '0;
   assign rsp_chan.data.filled          = head_valid;
   assign rsp_chan.data.last_of_run     = final_rank;

   // filled slots always form a prefix of the row
   a_valid_prefix : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("filled slots not contiguous from rank 0");

   // list empty once the final rank has gone
   a_clear_after_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_chan.data.last_of_run) |=> (valid_vec == '0 && state_ff == ST_FILL))
      else $error("list not cleared after final rank");

   // drain steps one rank per taken beat
   a_rank_step : assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && !rsp_chan.data.last_of_run) |=> (rank_ff == $past(rank_ff) + CNT_W'(1)))
      else $error("rank did not advance by one");

   // last edge starts a drain at rank zero
   a_drain_start : assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_chan.data.last_edge) |=> (state_ff == ST_DRAIN && rank_ff == '0))
      else $error("drain not started at rank zero");

endmodule

>>> bench/rank_list_checker.sv
`timescale 1ns / 100ps

// Watches the three channels, keeps its own copy of the sorted neighbour list
// and compares every rank beat with the oldest one still awaited.
module rank_list_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  tns_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  tns_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [tns_pkg::TCOUNT_W-1:0] csr_data,
   output int                       field_mismatches,
   output int                       ranks_awaited,
   output int                       ranks_compared
);
   import tns_pkg::*;

   localparam int SLOTS     = 64;
   localparam int DUE_DEPTH = 128;   // at most one vertex of ranks is ever pending

   logic [SIM_W-1:0]    list_sim   [SLOTS];
   logic [OUT_ID_W-1:0] list_id    [SLOTS];
   logic                slot_taken [SLOTS];
   logic [TCOUNT_W-1:0] t_setting;
   rsp_payload_type     ranks_due  [DUE_DEPTH];
   int                  due_wr;
   int                  due_rd;

   function automatic void clear_list();
      for (int i = 0; i < SLOTS; i++) begin
         list_sim[i]   = '0;
         list_id[i]    = '0;
         slot_taken[i] = 1'b0;
      end
   endfunction

   // new entry lands behind every held entry of equal or higher similarity
   function automatic void insert_neighbour(logic [OUT_ID_W-1:0] id, logic [SIM_W-1:0] sim);
      int pos;
      pos = 0;
      while (pos < SLOTS && slot_taken[pos] && list_sim[pos] >= sim)
         pos++;
      if (pos < SLOTS) begin
         for (int i = SLOTS - 1; i > pos; i--) begin
            list_sim[i]   = list_sim[i-1];
            list_id[i]    = list_id[i-1];
            slot_taken[i] = slot_taken[i-1];
         end
         list_sim[pos]   = sim;
         list_id[pos]    = id;
         slot_taken[pos] = 1'b1;
      end
   endfunction

   function automatic void emit_ranks();
      int t;
      rsp_payload_type beat;
      t = int'(t_setting);
      if (t == 0)
         t = 1;
      if (t > SLOTS)
         t = SLOTS;
      for (int k = 0; k < t; k++) begin
         beat.rank            = RANK_W'(k);
         beat.held_id         = slot_taken[k] ? list_id[k] : '0;
         beat.held_similarity = slot_taken[k] ? list_sim[k] : '0;
         beat.filled          = slot_taken[k];
         beat.last_of_run     = (k == t - 1);
         ranks_due[due_wr % DUE_DEPTH] = beat;
         due_wr++;
      end
      clear_list();
   endfunction

   function automatic void check_rank_beat(rsp_payload_type got);
      rsp_payload_type want;
      if (due_wr == due_rd) begin
         $error("rank beat with nothing awaited: rank %0d id %h", got.rank, got.held_id);
         field_mismatches++;
         return;
      end
      want = ranks_due[due_rd % DUE_DEPTH];
      due_rd++;
      ranks_compared++;
      if (got.rank !== want.rank) begin
         $error("rank: expected %0d, got %0d", want.rank, got.rank);
         field_mismatches++;
      end
      if (got.held_id !== want.held_id) begin
         $error("held_id: expected %h, got %h", want.held_id, got.held_id);
         field_mismatches++;
      end
      if (got.held_similarity !== want.held_similarity) begin
         $error("held_similarity: expected %h, got %h", want.held_similarity,
                got.held_similarity);
         field_mismatches++;
      end
      if (got.filled !== want.filled) begin
         $error("filled: expected %b, got %b", want.filled, got.filled);
         field_mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
         field_mismatches++;
      end
   endfunction

   initial begin
      field_mismatches = 0;
      ranks_awaited    = 0;
      ranks_compared   = 0;
      due_wr           = 0;
      due_rd           = 0;
      t_setting        = T_COUNT_RESET;
      clear_list();
   end

   // output beats are compared first: a beat taken on the edge that accepts
   // a last edge cannot belong to that vertex
   always @(posedge clock) begin
      if (reset) begin
         clear_list();
         t_setting = T_COUNT_RESET;
         due_wr    = 0;
         due_rd    = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_rank_beat(rsp_data);
         if (csr_valid && csr_ready)
            t_setting = csr_data;
         if (req_valid && req_ready) begin
            insert_neighbour(req_data.neighbor_id, req_data.similarity);
            if (req_data.last_edge)
               emit_ranks();
         end
      end
      ranks_awaited = due_wr - due_rd;
   end

endmodule

>>> bench/tb_top_t_neighbor_selection.sv
`timescale 1ns / 100ps

module tb_top_t_neighbor_selection;
   import tns_pkg::*;

   localparam int CYCLE_LIMIT = 250000;
   localparam int SETTLE      = 6;     // list is empty again the cycle after the final beat
   localparam int LONG_HOLD   = 300;   // receiver hold-off that backs up the drain
   localparam int GAP_MAX     = 14;
   localparam int EDGE_TARGET = 110;   // directed plus random edges, at least 110 in all
   localparam int LONG_VERTEX = 70;    // more edges than slots, forces drops

   logic clock;
   logic reset;

   tns_chan_if #(.payload_type(req_payload_type))       req_chan ();
   tns_chan_if #(.payload_type(rsp_payload_type))       rsp_chan ();
   tns_chan_if #(.payload_type(logic [TCOUNT_W-1:0]))   csr_chan ();

   int field_mismatches;
   int ranks_awaited;
   int ranks_compared;
   int cycle_count;

   // knobs shared between the stimulus and the receiver
   int req_gap_max;
   int rsp_gap_max;
   bit rsp_long_hold;
   int edges_sent;
   int vertices_sent;

   top_t_neighbor_selection uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   rank_list_checker rank_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_data         (req_chan.data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_data         (rsp_chan.data),
      .csr_valid        (csr_chan.valid),
      .csr_ready        (csr_chan.ready),
      .csr_data         (csr_chan.data),
      .field_mismatches (field_mismatches),
      .ranks_awaited    (ranks_awaited),
      .ranks_compared   (ranks_compared)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int draw_gap(int gap_top);
      return $urandom_range(gap_top, 0);
   endfunction

   // similarity mix: extremes, coarse values that tie often, and raw 17-bit
   // values (which include codes above 1.0)
   function automatic logic [SIM_W-1:0] pick_similarity();
      case ($urandom_range(5, 0))
         0:       return '0;
         1:       return SIM_W'(65536);
         2:       return SIM_W'($urandom_range(4, 0) * 16384);
         3:       return SIM_W'($urandom);
         default: return SIM_W'($urandom_range(65536, 0));
      endcase
   endfunction

   function automatic logic [OUT_ID_W-1:0] pick_id();
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return '1;
         default: return OUT_ID_W'($urandom);
      endcase
   endfunction

   // Entered just after a falling edge, returns just after the falling edge
   // that follows acceptance. With no gap valid simply stays high.
   task automatic send_edge(logic [OUT_ID_W-1:0] id, logic [SIM_W-1:0] sim, logic last);
      int gap;
      gap = draw_gap(req_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{neighbor_id: id, similarity: sim, last_edge: last};
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      edges_sent++;
      if (last)
         vertices_sent++;
   endtask

   // sender goes quiet until every rank beat has arrived, then lets the
   // block settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (ranks_awaited != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_t_count(logic [TCOUNT_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_random_vertex(int n_edges, bit coarse);
      logic [SIM_W-1:0] sim;
      for (int i = 0; i < n_edges; i++) begin
         sim = coarse ? SIM_W'($urandom_range(8, 0) * 8192) : pick_similarity();
         send_edge(pick_id(), sim, i == n_edges - 1);
      end
   endtask

   // receiver: random stall per beat, or one long hold-off when asked
   initial begin
      int stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_long_hold ? LONG_HOLD : draw_gap(rsp_gap_max);
         rsp_long_hold = 1'b0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int vtx;
      int n_edges;
      int pick;
      logic [TCOUNT_W-1:0] t_next;

      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      rsp_long_hold  = 1'b0;
      req_gap_max    = GAP_MAX;
      rsp_gap_max    = GAP_MAX;
      edges_sent     = 0;
      vertices_sent  = 0;

      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, t_count still at its reset value of 20 ----
      // lone zero-similarity edge: must still outrank the empty slots
      send_edge('0, '0, 1'b1);

      // extremes, a code above 1.0 and three-way plus top-end ties;
      // the older entry has to stay ahead in every tie
      send_edge('1, SIM_W'(65536), 1'b0);
      send_edge(32'h1234_5678, '1, 1'b0);
      send_edge(32'h0000_00A1, SIM_W'(100), 1'b0);
      send_edge(32'h0000_00A2, SIM_W'(100), 1'b0);
      send_edge(32'h0000_00A3, SIM_W'(100), 1'b0);
      send_edge(32'hDEAD_0000, '0, 1'b0);
      send_edge(32'h8000_0001, SIM_W'(65536), 1'b1);

      // single kept neighbour
      wait_idle();
      write_t_count(TCOUNT_W'(1));
      send_edge(32'h1, SIM_W'(5), 1'b0);
      send_edge(32'h2, SIM_W'(9), 1'b0);
      send_edge(32'h3, SIM_W'(9), 1'b1);

      // zero reads as one
      wait_idle();
      write_t_count('0);
      send_edge(32'h4, SIM_W'(7), 1'b0);
      send_edge(32'h5, SIM_W'(3), 1'b1);

      // full width: mostly empty slots on the way out
      wait_idle();
      write_t_count(TCOUNT_W'(64));
      send_edge(32'h6, SIM_W'(1), 1'b0);
      send_edge(32'h7, SIM_W'(2), 1'b1);

      // above the slot count saturates at 64
      wait_idle();
      write_t_count('1);
      send_edge(32'h8, SIM_W'(65536), 1'b1);

      // ---- random part ----
      vtx = 0;
      while (edges_sent < EDGE_TARGET) begin
         if (vtx == 2) begin
            // backpressure: receiver freezes mid-drain while the sender keeps
            // offering the next vertex, so the input has to stall
            wait_idle();
            write_t_count(TCOUNT_W'(20));
            req_gap_max   = 0;
            rsp_gap_max   = 0;
            rsp_long_hold = 1'b1;
            send_random_vertex(4, 1'b0);
            send_random_vertex(6, 1'b0);
         end else if (vtx == 5) begin
            // overfull list: later edges that do not beat the tail are dropped
            wait_idle();
            write_t_count(TCOUNT_W'(64));
            req_gap_max = draw_gap(1) * GAP_MAX;
            rsp_gap_max = draw_gap(1) * GAP_MAX;
            send_random_vertex(LONG_VERTEX, 1'b1);
         end else begin
            if ($urandom_range(2, 0) == 0) begin
               pick = $urandom_range(5, 0);
               case (pick)
                  0:       t_next = '0;
                  1:       t_next = TCOUNT_W'(1);
                  2:       t_next = TCOUNT_W'(64);
                  3:       t_next = '1;
                  default: t_next = TCOUNT_W'($urandom_range(127, 0));
               endcase
               wait_idle();
               write_t_count(t_next);
            end
            // some vertices run without any idling on one or both sides
            pick = $urandom_range(3, 0);
            req_gap_max = (pick == 1 || pick == 3) ? GAP_MAX : 0;
            rsp_gap_max = (pick == 2 || pick == 3) ? GAP_MAX : 0;
            n_edges = $urandom_range(10, 1);
            send_random_vertex(n_edges, $urandom_range(3, 0) == 0);
         end
         vtx++;
      end

      wait_idle();

      $display("Run covered %0d edges over %0d vertices, t_count at 0, 1, 20, 64, 127",
               edges_sent, vertices_sent);
      $display("and random values, ties, an overfull list and a %0d-cycle output hold; %0d rank beats compared.",
               LONG_HOLD, ranks_compared);
      if (field_mismatches == 0 && ranks_awaited == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
